// ===== hw/rtl/rrtt_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin task table package
// Shared types and codes for the task table and its stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

package rrtt_pkg;

  // Default number of task slots.
  localparam int unsigned RRTT_MAX_TASKS = 8;

  typedef enum logic [1:0] {
    CMD_CREATE    = 2'd0,
    CMD_YIELD     = 2'd1,
    CMD_TERMINATE = 2'd2,
    CMD_START     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_READY = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_DEAD  = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_RUN   = 2'd2
  } slot_state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        task_address;
    logic signed [15:0] task_argument;
    logic [1:0]         task_level;
  } task_req_t;

  typedef struct packed {
    logic [2:0]         run_slot;
    logic [15:0]        run_address;
    logic signed [15:0] run_argument;
    logic [1:0]         run_level;
    logic [2:0]         new_slot;
    logic [1:0]         status;
  } task_rsp_t;

  // Contents of one slot held in the slot memory.
  typedef struct packed {
    logic [15:0]        address;
    logic signed [15:0] argument;
    logic [1:0]         level;
  } slot_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrtt_stream_if.sv =====
// ----------------------------------------------------------------------------
// Task table stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrtt_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/round_robin_task_table.sv =====
// ----------------------------------------------------------------------------
// Round-robin task table
// Task slot table with create, yield, terminate and start commands and a
// round-robin dispatcher that picks the next ready slot.
// ----------------------------------------------------------------------------
// The block takes one command at a time and answers each with exactly one
// result transfer. A command is taken in the cycle it arrives; create and
// every dispatch then step a single slot comparator through the table, one
// slot per cycle. An ignored command skips the search; a search stops at the
// first hit, or after looking at every slot for a full table or an empty
// search. The result is then read and offered until it is taken. Slot
// contents live in a memory with a registered read port, read once per item
// for the running task. The input is not ready again until the result has
// been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_table #(
  parameter int unsigned MAX_TASKS = rrtt_pkg::RRTT_MAX_TASKS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rrtt_stream_if.sink        task_i,
  rrtt_stream_if.source      result_o
);

  import rrtt_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  typedef enum logic [3:0] {
    FSM_IDLE = 4'b0001,
    FSM_SCAN = 4'b0010,
    FSM_READ = 4'b0100,
    FSM_OUT  = 4'b1000
  } fsm_e;

  fsm_e               fsm_q, fsm_d;
  slot_state_e        slot_state_q [MAX_TASKS];
  slot_state_e        slot_state_d [MAX_TASKS];
  logic [IDX_W-1:0]   next_q, next_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic               started_q, started_d;
  logic               run_q, run_d;
  logic [CNT_W-1:0]   live_q, live_d;
  logic [IDX_W-1:0]   scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0]   scan_cnt_q, scan_cnt_d;
  logic               scan_create_q, scan_create_d;
  logic [IDX_W-1:0]   fresh_q, fresh_d;
  status_e            status_q, status_d;
  slot_entry_t        entry_q, entry_d;

  slot_entry_t        slot_mem [MAX_TASKS];
  slot_entry_t        rd_q;
  logic               mem_we;

  logic [IDX_W-1:0]   scan_idx_inc;
  slot_state_e        scan_target;
  logic               scan_hit;
  logic [IDX_W+2:0]   cur_ext;
  logic [IDX_W+2:0]   fresh_ext;

  assign scan_idx_inc = (scan_idx_q == LAST_IDX) ? '0 : scan_idx_q + IDX_W'(1);
  assign scan_target  = scan_create_q ? SLOT_DEAD : SLOT_READY;
  assign scan_hit     = (slot_state_q[scan_idx_q] == scan_target);
  assign mem_we       = (fsm_q == FSM_SCAN) && scan_hit && scan_create_q;

  always_comb begin
    fsm_d         = fsm_q;
    slot_state_d  = slot_state_q;
    next_d        = next_q;
    cur_d         = cur_q;
    started_d     = started_q;
    run_d         = run_q;
    live_d        = live_q;
    scan_idx_d    = scan_idx_q;
    scan_cnt_d    = scan_cnt_q;
    scan_create_d = scan_create_q;
    fresh_d       = fresh_q;
    status_d      = status_q;
    entry_d       = entry_q;

    unique case (fsm_q)
      FSM_IDLE: begin
        if (task_i.valid) begin
          entry_d.address  = task_i.payload.task_address;
          entry_d.argument = task_i.payload.task_argument;
          entry_d.level    = task_i.payload.task_level;
          fresh_d          = '0;
          status_d         = STAT_OK;
          scan_cnt_d       = '0;
          scan_idx_d       = next_q;
          scan_create_d    = 1'b0;
          fsm_d            = FSM_SCAN;
          unique case (cmd_e'(task_i.payload.command))
            CMD_CREATE: begin
              scan_create_d = 1'b1;
              scan_idx_d    = '0;
            end
            CMD_YIELD: begin
              if (!started_q) begin
                status_d = STAT_IGNORED;
                fsm_d    = FSM_READ;
              end else if (run_q) begin
                slot_state_d[cur_q] = SLOT_READY;
                run_d               = 1'b0;
              end
            end
            CMD_TERMINATE: begin
              if (!run_q) begin
                status_d = STAT_IGNORED;
                fsm_d    = FSM_READ;
              end else begin
                slot_state_d[cur_q] = SLOT_DEAD;
                run_d               = 1'b0;
                live_d              = live_q - CNT_W'(1);
              end
            end
            CMD_START: begin
              if (started_q || (live_q == '0)) begin
                status_d = STAT_IGNORED;
                fsm_d    = FSM_READ;
              end else begin
                started_d = 1'b1;
              end
            end
            default: fsm_d = FSM_READ;
          endcase
        end
      end

      FSM_SCAN: begin
        if (scan_hit) begin
          if (scan_create_q) begin
            slot_state_d[scan_idx_q] = SLOT_READY;
            live_d                   = live_q + CNT_W'(1);
            fresh_d                  = scan_idx_q;
          end else begin
            slot_state_d[scan_idx_q] = SLOT_RUN;
            cur_d                    = scan_idx_q;
            run_d                    = 1'b1;
            next_d                   = scan_idx_inc;
          end
          fsm_d = FSM_READ;
        end else if (scan_cnt_q == LAST_IDX) begin
          status_d = scan_create_q ? STAT_FULL : STAT_NO_READY;
          fsm_d    = FSM_READ;
        end else begin
          scan_idx_d = scan_idx_inc;
          scan_cnt_d = scan_cnt_q + IDX_W'(1);
        end
      end

      FSM_READ: fsm_d = FSM_OUT;

      FSM_OUT: begin
        if (result_o.ready) begin
          fsm_d = FSM_IDLE;
        end
      end

      default: fsm_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= FSM_IDLE;
      next_q    <= '0;
      cur_q     <= '0;
      started_q <= 1'b0;
      run_q     <= 1'b0;
      live_q    <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_state_q[i] <= SLOT_DEAD;
      end
    end else begin
      fsm_q        <= fsm_d;
      next_q       <= next_d;
      cur_q        <= cur_d;
      started_q    <= started_d;
      run_q        <= run_d;
      live_q       <= live_d;
      slot_state_q <= slot_state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q    <= scan_idx_d;
    scan_cnt_q    <= scan_cnt_d;
    scan_create_q <= scan_create_d;
    fresh_q       <= fresh_d;
    status_q      <= status_d;
    entry_q       <= entry_d;
  end

  // Slot memory: written by a successful create, read for the running task.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[scan_idx_q] <= entry_q;
    end
    if (fsm_q == FSM_READ) begin
      rd_q <= slot_mem[cur_q];
    end
  end

  // Slot indices are reported in three bits.
  assign cur_ext   = {3'b000, cur_q};
  assign fresh_ext = {3'b000, fresh_q};

  assign task_i.ready = (fsm_q == FSM_IDLE);

  assign result_o.valid                = (fsm_q == FSM_OUT);
  assign result_o.payload.run_slot     = run_q ? cur_ext[2:0] : 3'd0;
  assign result_o.payload.run_address  = run_q ? rd_q.address : 16'd0;
  assign result_o.payload.run_argument = run_q ? rd_q.argument : 16'sd0;
  assign result_o.payload.run_level    = run_q ? rd_q.level : 2'd0;
  assign result_o.payload.new_slot     = fresh_ext[2:0];
  assign result_o.payload.status       = status_q;

`ifndef SYNTHESIS
  a_run_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> started_q)
    else $error("task marked running before start");

  a_run_slot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (slot_state_q[cur_q] == SLOT_RUN))
    else $error("running slot is not in the running state");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(MAX_TASKS))
    else $error("live task count exceeds the table size");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (task_i.valid && task_i.ready) |=> !task_i.ready)
    else $error("new command taken while one is in progress");

  a_no_run_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (status_q == STAT_NO_READY)) |-> !run_q)
    else $error("empty search left a task running");
`endif

endmodule

`default_nettype wire

// ===== tb/round_robin_task_table_test.sv =====
// ----------------------------------------------------------------------------
// Round-robin task table testbench
// Drives create, yield, terminate and start commands into the task table,
// predicts every result with a behavioural copy of the slot table and
// compares each result transfer field by field, under random idling on both
// channels, a long result back-pressure stretch and a drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_table_test;

  timeunit 1ns;
  timeprecision 1ps;

  import rrtt_pkg::*;

  localparam int unsigned NUM_SLOTS    = RRTT_MAX_TASKS;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_FROM   = 500;
  localparam int unsigned QUIET_TO     = 700;
  localparam int unsigned DRAIN_AT     = 900;
  localparam int unsigned STALL_LIMIT  = 2000;
  // The slowest command walks the whole table once.
  localparam int unsigned TAIL_CYCLES  = 2 * NUM_SLOTS + 10;

  typedef struct {
    task_req_t req;
    bit        typed;
    task_rsp_t rsp;
  } directed_row_t;

  logic clk;
  logic rst_n;

  rrtt_stream_if #(.payload_t(task_req_t)) task_if ();
  rrtt_stream_if #(.payload_t(task_rsp_t)) result_if ();

  round_robin_task_table i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .task_i  (task_if),
    .result_o(result_if)
  );

  // Behavioural copy of the slot table.
  slot_state_e     tbl_state    [NUM_SLOTS];
  logic [15:0]     tbl_address  [NUM_SLOTS];
  logic [15:0]     tbl_argument [NUM_SLOTS];
  logic [1:0]      tbl_level    [NUM_SLOTS];
  int unsigned     tbl_next;
  int unsigned     tbl_current;
  int unsigned     tbl_live;
  bit              tbl_started;

  task_rsp_t       expected_results[$];
  directed_row_t   directed_rows[$];
  int unsigned     sent_count;
  int unsigned     checked_count;
  int unsigned     error_count;
  int unsigned     stall_cycles;
  int unsigned     command_seen [4];
  int unsigned     status_seen  [4];
  logic            hold_results;
  logic            quiet;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = ~clk;
  end

  function automatic bit task_running();
    return tbl_started && tbl_state[tbl_current] == SLOT_RUN;
  endfunction

  // Round-robin search from the next pointer; an empty search changes nothing.
  function automatic status_e dispatch_next();
    int unsigned pos;
    pos = tbl_next;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_state[pos] == SLOT_READY) begin
        tbl_current    = pos;
        tbl_state[pos] = SLOT_RUN;
        tbl_next       = (pos + 1) % NUM_SLOTS;
        return STAT_OK;
      end
      pos = (pos + 1) % NUM_SLOTS;
    end
    return STAT_NO_READY;
  endfunction

  function automatic task_rsp_t table_step(task_req_t req);
    task_rsp_t   rsp;
    status_e     st;
    int unsigned fresh;
    int          found;
    st    = STAT_OK;
    fresh = 0;
    found = -1;
    rsp   = '0;
    case (cmd_e'(req.command))
      CMD_CREATE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (found < 0 && tbl_state[i] == SLOT_DEAD) begin
            found = i;
          end
        end
        if (found < 0) begin
          st = STAT_FULL;
        end else begin
          tbl_address[found]  = req.task_address;
          tbl_argument[found] = req.task_argument;
          tbl_level[found]    = req.task_level;
          tbl_state[found]    = SLOT_READY;
          tbl_live++;
          fresh = found;
        end
      end
      CMD_YIELD: begin
        if (!tbl_started) begin
          st = STAT_IGNORED;
        end else begin
          if (task_running()) begin
            tbl_state[tbl_current] = SLOT_READY;
          end
          st = dispatch_next();
        end
      end
      CMD_TERMINATE: begin
        if (!task_running()) begin
          st = STAT_IGNORED;
        end else begin
          tbl_state[tbl_current] = SLOT_DEAD;
          if (tbl_live > 0) begin
            tbl_live--;
          end
          st = dispatch_next();
        end
      end
      default: begin
        if (tbl_started || tbl_live == 0) begin
          st = STAT_IGNORED;
        end else begin
          tbl_started = 1'b1;
          st = dispatch_next();
        end
      end
    endcase
    if (task_running()) begin
      rsp.run_slot     = 3'(tbl_current);
      rsp.run_address  = tbl_address[tbl_current];
      rsp.run_argument = tbl_argument[tbl_current];
      rsp.run_level    = tbl_level[tbl_current];
    end
    rsp.new_slot = 3'(fresh);
    rsp.status   = st;
    return rsp;
  endfunction

  function automatic task_rsp_t rsp_of(int unsigned slot, logic [15:0] addr,
                                       logic signed [15:0] arg, logic [1:0] lvl,
                                       int unsigned fresh, status_e st);
    task_rsp_t r;
    r.run_slot     = 3'(slot);
    r.run_address  = addr;
    r.run_argument = arg;
    r.run_level    = lvl;
    r.new_slot     = 3'(fresh);
    r.status       = st;
    return r;
  endfunction

  function automatic task_req_t req_of(cmd_e cmd, logic [15:0] addr,
                                       logic signed [15:0] arg, logic [1:0] lvl);
    task_req_t r;
    r.command       = cmd;
    r.task_address  = addr;
    r.task_argument = arg;
    r.task_level    = lvl;
    return r;
  endfunction

  task automatic add_row(cmd_e cmd, logic [15:0] addr, logic signed [15:0] arg,
                         logic [1:0] lvl, bit typed, task_rsp_t rsp);
    directed_row_t row;
    row.req   = req_of(cmd, addr, arg, lvl);
    row.typed = typed;
    row.rsp   = rsp;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    error_count++;
    $display("[%0t] mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
             $realtime, checked_count, field, got, want);
  endtask

  // Both sides look at the same edge; the expectation is queued at the
  // transfer of the command, well before its result can appear.
  task automatic send_item(task_req_t req, bit typed, task_rsp_t typed_rsp);
    task_rsp_t want;
    task_if.payload <= req;
    task_if.valid   <= 1'b1;
    do begin
      @(posedge clk);
    end while (!task_if.ready);
    want = table_step(req);
    if (typed) begin
      want = typed_rsp;
    end
    expected_results.push_back(want);
    command_seen[req.command]++;
    status_seen[want.status]++;
    sent_count++;
    quiet <= (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
    if (sent_count == DRAIN_AT) begin
      task_if.valid <= 1'b0;
      while (expected_results.size() != 0) begin
        @(posedge clk);
      end
    end else if (!(sent_count >= QUIET_FROM && sent_count < QUIET_TO) &&
                 $urandom_range(0, 99) < 12) begin
      task_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_argument();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: check each transfer, then decide whether to take the next.
  always @(posedge clk) begin
    task_rsp_t want;
    task_rsp_t got;
    if (rst_n) begin
      if (result_if.valid && result_if.ready) begin
        got = result_if.payload;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("[%0t] result transfer with no command outstanding", $realtime);
        end else begin
          want = expected_results.pop_front();
          if (got.run_slot !== want.run_slot)
            report_mismatch("run_slot", got.run_slot, want.run_slot);
          if (got.run_address !== want.run_address)
            report_mismatch("run_address", got.run_address, want.run_address);
          if (got.run_argument !== want.run_argument)
            report_mismatch("run_argument", got.run_argument, want.run_argument);
          if (got.run_level !== want.run_level)
            report_mismatch("run_level", got.run_level, want.run_level);
          if (got.new_slot !== want.new_slot)
            report_mismatch("new_slot", got.new_slot, want.new_slot);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        end
        checked_count++;
      end
      result_if.ready <= !(hold_results || (!quiet && $urandom_range(0, 99) < 12));
    end else begin
      result_if.ready <= 1'b0;
    end
  end

  // One long back-pressure stretch, so that the table stalls its input.
  initial begin
    hold_results <= 1'b0;
    wait (sent_count >= HOLD_AT);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((task_if.valid && task_if.ready) || (result_if.valid && result_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timed out after %0d cycles without a transfer", stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    task_rsp_t   none;
    task_req_t   req;
    int unsigned w_create;
    int unsigned w_yield;
    int unsigned w_term;
    int unsigned w_start;
    int unsigned pick;
    none = '0;
    rst_n            = 1'b0;
    task_if.valid   <= 1'b0;
    task_if.payload <= '0;
    quiet           <= 1'b0;
    sent_count       = 0;
    checked_count    = 0;
    error_count      = 0;
    tbl_next         = 0;
    tbl_current      = 0;
    tbl_live         = 0;
    tbl_started      = 1'b0;
    foreach (tbl_state[i]) begin
      tbl_state[i]    = SLOT_DEAD;
      tbl_address[i]  = '0;
      tbl_argument[i] = '0;
      tbl_level[i]    = '0;
    end
    foreach (command_seen[i]) begin
      command_seen[i] = 0;
      status_seen[i]  = 0;
    end

    // Nothing may run before start, and start needs a live task.
    add_row(CMD_YIELD, 16'h0, 16'sh0, 2'd0, 1'b1, rsp_of(0, 0, 0, 0, 0, STAT_IGNORED));
    add_row(CMD_TERMINATE, 16'h0, 16'sh0, 2'd0, 1'b1, rsp_of(0, 0, 0, 0, 0, STAT_IGNORED));
    add_row(CMD_START, 16'h0, 16'sh0, 2'd0, 1'b1, rsp_of(0, 0, 0, 0, 0, STAT_IGNORED));
    add_row(CMD_CREATE, 16'hFFFF, 16'sh8000, 2'd3, 1'b1, rsp_of(0, 0, 0, 0, 0, STAT_OK));
    add_row(CMD_CREATE, 16'h0000, 16'sh7FFF, 2'd0, 1'b1, rsp_of(0, 0, 0, 0, 1, STAT_OK));
    add_row(CMD_START, 16'h0, 16'sh0, 2'd0, 1'b1,
            rsp_of(0, 16'hFFFF, 16'sh8000, 2'd3, 0, STAT_OK));
    add_row(CMD_START, 16'h0, 16'sh0, 2'd0, 1'b1,
            rsp_of(0, 16'hFFFF, 16'sh8000, 2'd3, 0, STAT_IGNORED));
    add_row(CMD_YIELD, 16'h0, 16'sh0, 2'd0, 1'b1,
            rsp_of(1, 16'h0000, 16'sh7FFF, 2'd0, 0, STAT_OK));
    for (int i = 2; i < NUM_SLOTS; i++) begin
      add_row(CMD_CREATE, 16'(16'h1111 * i), 16'(-i), 2'(i), 1'b0, none);
    end
    add_row(CMD_CREATE, 16'hA5A5, 16'sh5A5A, 2'd2, 1'b1,
            rsp_of(1, 16'h0000, 16'sh7FFF, 2'd0, 0, STAT_FULL));
    // Kill every task in turn; the last one leaves an empty search.
    for (int i = 1; i < NUM_SLOTS; i++) begin
      add_row(CMD_TERMINATE, 16'h0, 16'sh0, 2'd0, 1'b0, none);
    end
    add_row(CMD_TERMINATE, 16'h0, 16'sh0, 2'd0, 1'b1, rsp_of(0, 0, 0, 0, 0, STAT_NO_READY));
    add_row(CMD_TERMINATE, 16'h0, 16'sh0, 2'd0, 1'b1, rsp_of(0, 0, 0, 0, 0, STAT_IGNORED));
    add_row(CMD_YIELD, 16'h0, 16'sh0, 2'd0, 1'b1, rsp_of(0, 0, 0, 0, 0, STAT_NO_READY));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end

    // Random part in short blocks, each leaning towards filling or emptying
    // the table, so that full tables and empty searches both recur.
    w_create = 0;
    w_yield  = 0;
    w_term   = 0;
    w_start  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        w_create = $urandom_range(10, 60);
        w_yield  = $urandom_range(10, 40);
        w_term   = $urandom_range(10, 50);
        w_start  = $urandom_range(1, 5);
      end
      pick = $urandom_range(0, w_create + w_yield + w_term + w_start - 1);
      if (pick < w_create) begin
        req = req_of(CMD_CREATE, pick_address(), pick_argument(), 2'($urandom));
      end else if (pick < w_create + w_yield) begin
        req = req_of(CMD_YIELD, 16'($urandom), 16'($urandom), 2'($urandom));
      end else if (pick < w_create + w_yield + w_term) begin
        req = req_of(CMD_TERMINATE, 16'($urandom), 16'($urandom), 2'($urandom));
      end else begin
        req = req_of(CMD_START, 16'($urandom), 16'($urandom), 2'($urandom));
      end
      send_item(req, 1'b0, none);
    end
    task_if.valid <= 1'b0;

    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Commands sent: %0d create, %0d yield, %0d terminate, %0d start; %0d results checked",
             command_seen[CMD_CREATE], command_seen[CMD_YIELD],
             command_seen[CMD_TERMINATE], command_seen[CMD_START], checked_count);
    $display("Statuses seen: %0d ok, %0d table full, %0d no ready task, %0d ignored",
             status_seen[STAT_OK], status_seen[STAT_FULL],
             status_seen[STAT_NO_READY], status_seen[STAT_IGNORED]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== round_robin_task_table.f =====
hw/rtl/rrtt_pkg.sv
hw/rtl/rrtt_stream_if.sv
hw/rtl/round_robin_task_table.sv
tb/round_robin_task_table_test.sv
